FILE: src/aes128_block_encrypt_macros.svh
// Assertion macros shared by the checker of the AES-128 encryption block.
// Holds only macro definitions; no dependencies.
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: src/aes_pkg.sv
// Package of the AES-128 encryption block: widths, register indexes, GF helpers.
// No dependencies.
package aes_pkg;
   localparam int BlockWidth = 128;
   localparam int HalfWidth  = 64;
   localparam int NumRounds  = 10;
   localparam int AddrWidth  = 4;
   localparam logic [AddrWidth-1:0] RegKeyHigh = 4'h0;
   localparam logic [AddrWidth-1:0] RegKeyLow  = 4'h8;

   typedef logic [BlockWidth-1:0] block_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      logic [7:0] d;
      d = {a[6:0], 1'b0};
      if (a[7]) d = d ^ 8'h1b;
      return d;
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 7; i >= 0; i--) begin
         acc = xtime(acc);
         if (b[i]) acc = acc ^ a;
      end
      return acc;
   endfunction

   // S-box entry computed at elaboration; used only to build the table.
   function automatic logic [7:0] sbox_calc(input logic [7:0] a);
      logic [7:0] sq;
      logic [7:0] inv;
      sq = a;
      inv = 8'h01;
      for (int i = 0; i < 7; i++) begin
         sq = gf_mul(sq, sq);
         inv = gf_mul(inv, sq);
      end
      return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
   endfunction

   typedef logic [7:0] sbox_table_type [256];

   function automatic sbox_table_type build_sbox();
      sbox_table_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox_calc(i[7:0]);
      return t;
   endfunction

   localparam sbox_table_type SboxTable = build_sbox();

   function automatic logic [7:0] sbox(input logic [7:0] a);
      return SboxTable[a];
   endfunction

   typedef logic [7:0] rcon_table_type [NumRounds];
   localparam rcon_table_type RconTable = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                            8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

   // Byte i of a block sits in bits 127-8i .. 120-8i.
   function automatic logic [7:0] get_byte(input block_type b, input int i);
      return b[BlockWidth-1-8*i -: 8];
   endfunction
endpackage

FILE: src/aes_if.sv
// Valid/ready channel carrying one 128-bit word as two 64-bit halves.
// Depends on aes_pkg for the half width.
interface aes_if;
   import aes_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [HalfWidth-1:0] high;
   logic [HalfWidth-1:0] low;
   modport source (output valid, output high, output low, input ready);
   modport sink   (input valid, input high, input low, output ready);
endinterface

FILE: src/aes_round_cell.sv
// One round cell of the AES pipeline: round transform plus on-the-fly key step.
// Depends on aes_pkg.
module aes_round_cell #(
   parameter int Round = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              valid_in,
   input  aes_pkg::block_type state_in,
   input  aes_pkg::block_type key_in,
   output logic              valid_out,
   output aes_pkg::block_type state_out,
   output aes_pkg::block_type key_out
);
   import aes_pkg::*;

   localparam bit FinalRound = (Round == NumRounds - 1);

   logic      valid_ff, valid_in_d;
   block_type state_ff, state_in_d;
   block_type key_ff, key_in_d;
   logic [7:0] s [16];
   logic [7:0] t [16];
   logic [7:0] k [16];

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            s[4*c+r] = sbox(get_byte(state_in, 4*((c + r) % 4) + r));
         end
      end
      for (int c = 0; c < 4; c++) begin
         if (FinalRound) begin
            for (int r = 0; r < 4; r++) t[4*c+r] = s[4*c+r];
         end else begin
            t[4*c]   = xtime(s[4*c]) ^ xtime(s[4*c+1]) ^ s[4*c+1] ^ s[4*c+2] ^ s[4*c+3];
            t[4*c+1] = s[4*c] ^ xtime(s[4*c+1]) ^ xtime(s[4*c+2]) ^ s[4*c+2] ^ s[4*c+3];
            t[4*c+2] = s[4*c] ^ s[4*c+1] ^ xtime(s[4*c+2]) ^ xtime(s[4*c+3]) ^ s[4*c+3];
            t[4*c+3] = xtime(s[4*c]) ^ s[4*c] ^ s[4*c+1] ^ s[4*c+2] ^ xtime(s[4*c+3]);
         end
      end
      k[0] = get_byte(key_in, 0) ^ sbox(get_byte(key_in, 13)) ^ RconTable[Round];
      k[1] = get_byte(key_in, 1) ^ sbox(get_byte(key_in, 14));
      k[2] = get_byte(key_in, 2) ^ sbox(get_byte(key_in, 15));
      k[3] = get_byte(key_in, 3) ^ sbox(get_byte(key_in, 12));
      for (int i = 4; i < 16; i++) k[i] = get_byte(key_in, i) ^ k[i-4];
      for (int i = 0; i < 16; i++) begin
         key_in_d[BlockWidth-1-8*i -: 8]   = k[i];
         state_in_d[BlockWidth-1-8*i -: 8] = t[i] ^ k[i];
      end
      valid_in_d = valid_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in_d;
      end
      if (advance) begin
         state_ff <= state_in_d;
         key_ff   <= key_in_d;
      end
   end

   assign valid_out = valid_ff;
   assign state_out = state_ff;
   assign key_out   = key_ff;
endmodule

FILE: src/aes_csr.sv
// APB-style key register file of the AES block: two 64-bit key registers.
// Depends on aes_pkg.
module aes_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [aes_pkg::AddrWidth-1:0] paddr,
   input  logic [aes_pkg::HalfWidth-1:0] pwdata,
   output logic [aes_pkg::HalfWidth-1:0] prdata,
   output logic                          pready,
   output aes_pkg::block_type            key
);
   import aes_pkg::*;

   logic [HalfWidth-1:0] key_high_ff, key_high_in;
   logic [HalfWidth-1:0] key_low_ff, key_low_in;
   logic                 wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;

   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      case (paddr)
         RegKeyHigh: if (wr_en) key_high_in = pwdata;
         RegKeyLow:  if (wr_en) key_low_in = pwdata;
         default:    ;
      endcase
   end

   always_comb begin
      case (paddr)
         RegKeyHigh: prdata = key_high_ff;
         RegKeyLow:  prdata = key_low_ff;
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else begin
         key_high_ff <= key_high_in;
         key_low_ff  <= key_low_in;
      end
   end

   assign key = {key_high_ff, key_low_ff};
endmodule

FILE: src/aes128_block_encrypt.sv
// AES-128 encryption core: a row of ten round cells, one per AES round.
// A word passes through the input stage and then the ten round cells before its result word appears.
// Throughput is one word per cycle; the whole row stalls only when the result is not taken.
// Reset (synchronous, active high) clears every valid bit and both key registers to zero.
module aes128_block_encrypt (
   input  logic                          clock,
   input  logic                          reset,
   aes_if.sink                           req,
   aes_if.source                         rsp,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [aes_pkg::AddrWidth-1:0] csr_paddr,
   input  logic [aes_pkg::HalfWidth-1:0] csr_pwdata,
   output logic [aes_pkg::HalfWidth-1:0] csr_prdata,
   output logic                          csr_pready
);
   import aes_pkg::*;

   // The key is sampled together with the plaintext at the input stage and then
   // travels down the row beside the data, each cell deriving its round key.
   block_type key;
   logic      advance;
   logic      in_valid_ff;
   block_type in_state_ff, in_key_ff;

   logic      v   [NumRounds+1];
   block_type st  [NumRounds+1];
   block_type rk  [NumRounds+1];

   aes_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .key     (key)
   );

   // The row moves whenever the last cell is empty or its word is being taken,
   // and req.ready is that same signal, so it follows rsp.ready combinationally.
   assign advance   = ~rsp.valid | rsp.ready;
   assign req.ready = advance;

   // Input stage holds the plaintext already xored with the initial round key.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req.valid;
      end
      if (advance) begin
         in_state_ff <= {req.high, req.low} ^ key;
         in_key_ff   <= key;
      end
   end

   assign v[0]  = in_valid_ff;
   assign st[0] = in_state_ff;
   assign rk[0] = in_key_ff;

   for (genvar g = 0; g < NumRounds; g++) begin : g_round
      aes_round_cell #(.Round(g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (v[g]),
         .state_in  (st[g]),
         .key_in    (rk[g]),
         .valid_out (v[g+1]),
         .state_out (st[g+1]),
         .key_out   (rk[g+1])
      );
   end

   assign rsp.valid = v[NumRounds];
   assign rsp.high  = st[NumRounds][BlockWidth-1 -: HalfWidth];
   assign rsp.low   = st[NumRounds][HalfWidth-1:0];
endmodule

FILE: src/aes128_block_encrypt_checker.sv
// Port-level checker for the AES-128 encryption core, bound to the top level.
// Depends on aes_pkg and the assertion macro header.
`include "aes128_block_encrypt_macros.svh"
module aes128_block_encrypt_props (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [aes_pkg::HalfWidth-1:0] rsp_high,
   input logic                 csr_pready
);
   import aes_pkg::*;

   `AES_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "input stalled")
   `AES_ASSERT_IMPL(a_stall_follows_output, clock, reset, rsp_valid && !rsp_ready, !req_ready, "input taken")
   `AES_ASSERT_NEXT(a_result_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_high), "result changed")
   `AES_ASSERT_IMPL(a_pready, clock, reset, 1'b1, csr_pready, "pready low")
endmodule

bind aes128_block_encrypt aes128_block_encrypt_props u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_high   (rsp.high),
   .csr_pready (csr_pready)
);

FILE: tb/aes128_block_encrypt_checker.sv
// Scoreboard for the AES-128 encryption block: watches both word channels,
// predicts ciphertext from its own copy of the key, and counts mismatches.
// Depends on aes_pkg and aes_if.
module aes128_block_encrypt_checker (
   input  logic                  clock,
   input  logic                  reset,
   aes_if                        req,
   aes_if                        rsp,
   input  logic [127:0]          cipher_key,
   output int                    fail_count,
   output int                    pending_count
);
   import aes_pkg::*;

   logic [127:0] expected_cipher[$];

   function automatic logic [7:0] mul2(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   // Inverse as a^254 then the affine map; zero inverts to zero and so maps to 8'h63.
   function automatic logic [7:0] subst(input logic [7:0] a);
      logic [7:0] sq, inv, x, acc;
      sq = a;
      inv = 8'h01;
      for (int i = 0; i < 7; i++) begin
         acc = 8'h00;
         for (int k = 7; k >= 0; k--) begin
            acc = mul2(acc);
            if (sq[k]) acc = acc ^ sq;
         end
         sq = acc;
         acc = 8'h00;
         for (int k = 7; k >= 0; k--) begin
            acc = mul2(acc);
            if (sq[k]) acc = acc ^ inv;
         end
         inv = acc;
      end
      x = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return x;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] plain,
                                                  input logic [127:0] key);
      logic [7:0] s[16], t[16], rk[16];
      logic [7:0] rcon[10];
      logic [7:0] a0, a1, a2, a3;
      logic [127:0] result;
      rcon = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};
      for (int i = 0; i < 16; i++) begin
         s[i] = plain[127-8*i -: 8];
         rk[i] = key[127-8*i -: 8];
         s[i] = s[i] ^ rk[i];
      end
      for (int r = 0; r < 10; r++) begin
         for (int c = 0; c < 4; c++)
            for (int w = 0; w < 4; w++)
               t[4*c+w] = subst(s[4*((c+w)%4)+w]);
         s = t;
         if (r < 9) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               s[4*c]   = mul2(a0) ^ mul2(a1) ^ a1 ^ a2 ^ a3;
               s[4*c+1] = a0 ^ mul2(a1) ^ mul2(a2) ^ a2 ^ a3;
               s[4*c+2] = a0 ^ a1 ^ mul2(a2) ^ mul2(a3) ^ a3;
               s[4*c+3] = mul2(a0) ^ a0 ^ a1 ^ a2 ^ mul2(a3);
            end
         end
         rk[0] = rk[0] ^ subst(rk[13]) ^ rcon[r];
         rk[1] = rk[1] ^ subst(rk[14]);
         rk[2] = rk[2] ^ subst(rk[15]);
         rk[3] = rk[3] ^ subst(rk[12]);
         for (int i = 4; i < 16; i++) rk[i] = rk[i] ^ rk[i-4];
         for (int i = 0; i < 16; i++) s[i] = s[i] ^ rk[i];
      end
      for (int i = 0; i < 16; i++) result[127-8*i -: 8] = s[i];
      return result;
   endfunction

   assign pending_count = expected_cipher.size();

   always @(posedge clock) begin
      logic [127:0] want;
      int errs;
      errs = 0;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req.valid && req.ready)
            expected_cipher.push_back(encrypt_block({req.high, req.low}, cipher_key));
         if (rsp.valid && rsp.ready) begin
            if (expected_cipher.size() == 0) begin
               $display("%0t: unexpected word %h_%h", $time, rsp.high, rsp.low);
               errs = errs + 1;
            end else begin
               want = expected_cipher.pop_front();
               if (rsp.high !== want[127:64]) begin
                  $display("%0t: cipher_high expected %h actual %h", $time,
                           want[127:64], rsp.high);
                  errs = errs + 1;
               end
               if (rsp.low !== want[63:0]) begin
                  $display("%0t: cipher_low expected %h actual %h", $time,
                           want[63:0], rsp.low);
                  errs = errs + 1;
               end
            end
         end
         if (errs != 0) fail_count <= fail_count + errs;
      end
   end
endmodule

FILE: tb/aes128_block_encrypt_tb.sv
// Top level of the AES-128 encryption testbench: clock, reset, key writes over
// the register port, plaintext stimulus and back-pressure. Depends on aes_pkg,
// aes_if, the block and aes128_block_encrypt_checker.
module aes128_block_encrypt_tb;
   import aes_pkg::*;

   localparam int Latency = 11;
   localparam int WatchdogLimit = 20000;

   logic clock;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [AddrWidth-1:0] csr_paddr;
   logic [HalfWidth-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic [127:0] cipher_key;
   int fail_count, pending_count;
   int idle_pct, stall_pct;
   int quiet_cycles;

   aes_if req ();
   aes_if rsp ();

   aes128_block_encrypt DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   aes128_block_encrypt_checker checker_inst (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .cipher_key(cipher_key),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The receiver stalls at random; the percentage is set per phase.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: cycles with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("aes128_block_encrypt_tb: FAIL");
            $finish;
         end
      end
   end

   // Register write in a setup and an access phase; the checker's key copy follows at the write edge.
   task automatic write_reg(input logic [AddrWidth-1:0] addr, input logic [63:0] data);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (addr == RegKeyHigh) cipher_key[127:64] = data;
      else if (addr == RegKeyLow) cipher_key[63:0] = data;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
   endtask

   // Send one word, with a random idle gap first, and hold it until accepted.
   task automatic send_word(input logic [63:0] hi, input logic [63:0] lo);
      if (idle_pct > 0) begin
         while ($urandom_range(99) < idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req.valid <= 1'b1; req.high <= hi; req.low <= lo;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Random half biased toward all-zero, all-one and single-bit patterns.
   function automatic logic [63:0] pick_half();
      case ($urandom_range(7))
         0: return 64'h0;
         1: return '1;
         2: return 64'h1 << $urandom_range(63);
         3: return ~(64'h1 << $urandom_range(63));
         default: return rand64();
      endcase
   endfunction

   initial begin
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      req.valid = 1'b0; req.high = '0; req.low = '0;
      cipher_key = '0;
      idle_pct = 0; stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: the zero key from reset first, then the FIPS-197 example key, then an all-ones key.
      send_word(64'h0, 64'h0);
      send_word('1, '1);
      drain();
      write_reg(RegKeyHigh, 64'h0001020304050607);
      write_reg(RegKeyLow, 64'h08090a0b0c0d0e0f);
      send_word(64'h0011223344556677, 64'h8899aabbccddeeff);
      send_word(64'h0, 64'h0);
      send_word('1, '1);
      for (int b = 0; b < 8; b++) send_word(64'h1 << (8 * b + b), ~(64'h1 << (63 - 8 * b)));
      drain();
      write_reg(RegKeyHigh, '1);
      write_reg(RegKeyLow, '1);
      send_word(64'h0, 64'h0);
      send_word('1, '1);
      send_word(64'h8000000000000000, 64'h1);
      drain();

      // Random phases, each under a fresh key and one of four idle and stall patterns.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         write_reg(RegKeyHigh, pick_half());
         write_reg(RegKeyLow, pick_half());
         for (int n = 0; n < 250; n++) begin
            // Halfway through each phase the sender waits for every pending word to return.
            if (n == 125) drain();
            send_word(pick_half(), pick_half());
         end
         drain();
      end

      stall_pct = 0;
      drain();
      if (fail_count == 0) begin
         $display("aes128_block_encrypt_tb: PASS");
      end else begin
         $display("aes128_block_encrypt_tb: FAIL");
      end
      $finish;
   end
endmodule
